FILE: src/bpsf_pkg.sv
package bpsf_pkg;

  localparam int FACTOR_BITS_DEF = 16;

  localparam int CFG_AW  = 4;
  localparam int DATA_W  = 32;
  localparam int SHINE_W = 16;

  localparam int VEC_W   = 33;
  localparam int U_W     = 32;
  localparam int MAG_W   = 30;
  localparam int LEN_W   = 31;
  localparam int REM_W   = LEN_W + 1;
  localparam int SUM_W   = 2 * MAG_W + 2;
  localparam int MSB_W   = $clog2(VEC_W);

  localparam int Q_FRAC   = 30;
  localparam int BASE_W   = Q_FRAC + 1;
  localparam int LOG_FRAC = 24;
  localparam int K_W      = 5;
  localparam int COEF_W   = 30;

  localparam int SQ_N     = LEN_W;
  localparam int DV_N     = LEN_W;
  localparam int NORM_LAT = 5 + SQ_N + DV_N + 1;
  localparam int POW_LAT  = 2 + LOG_FRAC + 2 + LOG_FRAC + 1;
  localparam int LAT      = 2 * NORM_LAT + POW_LAT + 6;

  localparam logic [BASE_W-1:0] ONE_Q30 = BASE_W'(1) << Q_FRAC;

  typedef enum logic [1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2
  } cfg_reg_t;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [U_W-1:0]   unit_t;
  typedef logic [MAG_W-1:0]        mag_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
  } sqs_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] q;
  } dvs_t;

  typedef logic [COEF_W-1:0] coef_tab_t [LOG_FRAC];

  function automatic sqs_t sqrt_step(input sqs_t s, input logic [1:0] pair);
    logic [REM_W+1:0] cat;
    logic [REM_W+1:0] t;
    sqs_t o;
    cat = {s.rem, pair};
    t = {1'b0, s.root, 2'b01};
    if (cat >= t) begin
      o.rem  = REM_W'(cat - t);
      o.root = {s.root[LEN_W-2:0], 1'b1};
    end else begin
      o.rem  = cat[REM_W-1:0];
      o.root = {s.root[LEN_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dvs_t div_step(input logic [LEN_W-1:0] rem, input logic [LEN_W-1:0] q,
                                    input logic nbit, input logic [LEN_W-1:0] d);
    logic [LEN_W:0] cat;
    dvs_t o;
    cat = {rem, nbit};
    if (cat >= {1'b0, d}) begin
      o.rem = LEN_W'(cat - {1'b0, d});
      o.q   = {q[LEN_W-2:0], 1'b1};
    end else begin
      o.rem = cat[LEN_W-1:0];
      o.q   = {q[LEN_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    int j;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  // c(i) = 2^(-2^-(i+1)) in Q.30
  function automatic coef_tab_t coef_tab();
    coef_tab_t t;
    int j;
    t[0] = COEF_W'(isqrt64(64'd1 << 59));
    for (j = 1; j < LOG_FRAC; j++) begin
      t[j] = COEF_W'(isqrt64({34'd0, t[j-1]} << Q_FRAC));
    end
    return t;
  endfunction

endpackage

FILE: src/bpsf_norm3.sv
module bpsf_norm3 import bpsf_pkg::*; (
  input  logic  clk,
  input  vec_t  vec_i [3],
  output unit_t unit_o [3],
  output logic  zero_o
);

  logic [VEC_W-1:0] abs_c [3];
  logic [VEC_W-1:0] abs1_r [3];
  logic [VEC_W-1:0] abs2_r [3];
  logic [VEC_W-1:0] m_c, m1_r;
  logic [2:0]       neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [MSB_W-1:0] msb_c, msb2_r;
  logic             zero2_r, zero3_r, zero4_r, zero5_r;
  logic [VEC_W-1:0] sh_c [3];
  mag_t             mag_c [3];
  mag_t             mag3_r [3];
  mag_t             mag4_r [3];
  mag_t             mag5_r [3];
  logic [2*MAG_W-1:0] sq4_r [3];
  logic [SUM_W-1:0] sum5_r;

  sqs_t             sq_st_r [SQ_N];
  logic [SUM_W-1:0] sq_x_r [SQ_N];
  mag_t             sq_mag_r [SQ_N][3];
  logic [2:0]       sq_neg_r [SQ_N];
  logic             sq_zero_r [SQ_N];

  dvs_t             dv_st_r [DV_N][3];
  logic [LEN_W-1:0] dv_len_r [DV_N];
  logic [2:0]       dv_neg_r [DV_N];
  logic             dv_zero_r [DV_N];

  unit_t            unit_r [3];
  logic             zero_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = vec_i[i][VEC_W-1] ? $unsigned(-vec_i[i]) : $unsigned(vec_i[i]);
    end
    m_c = abs_c[0];
    if (abs_c[1] > m_c) m_c = abs_c[1];
    if (abs_c[2] > m_c) m_c = abs_c[2];
  end

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (m1_r[b]) msb_c = MSB_W'(b);
    end
  end

  // bring the largest magnitude into [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb2_r >= MSB_W'(MAG_W - 1)) begin
        sh_c[i] = abs2_r[i] >> (msb2_r - MSB_W'(MAG_W - 1));
      end else begin
        sh_c[i] = abs2_r[i] << (MSB_W'(MAG_W - 1) - msb2_r);
      end
      mag_c[i] = sh_c[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      abs1_r[i] <= abs_c[i];
      neg1_r[i] <= vec_i[i][VEC_W-1];
      abs2_r[i] <= abs1_r[i];
      mag3_r[i] <= mag_c[i];
      sq4_r[i]  <= mag3_r[i] * mag3_r[i];
      mag4_r[i] <= mag3_r[i];
      mag5_r[i] <= mag4_r[i];
    end
    m1_r    <= m_c;
    msb2_r  <= msb_c;
    zero2_r <= (m1_r == '0);
    neg2_r  <= neg1_r;
    neg3_r  <= neg2_r;
    zero3_r <= zero2_r;
    neg4_r  <= neg3_r;
    zero4_r <= zero3_r;
    sum5_r  <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]);
    neg5_r  <= neg4_r;
    zero5_r <= zero4_r;
  end

  // square root, one result bit a stage
  always_ff @(posedge clk) begin
    sq_st_r[0]   <= sqrt_step('0, sum5_r[SUM_W-1:SUM_W-2]);
    sq_x_r[0]    <= sum5_r << 2;
    sq_mag_r[0]  <= mag5_r;
    sq_neg_r[0]  <= neg5_r;
    sq_zero_r[0] <= zero5_r;
    for (int j = 1; j < SQ_N; j++) begin
      sq_st_r[j]   <= sqrt_step(sq_st_r[j-1], sq_x_r[j-1][SUM_W-1:SUM_W-2]);
      sq_x_r[j]    <= sq_x_r[j-1] << 2;
      sq_mag_r[j]  <= sq_mag_r[j-1];
      sq_neg_r[j]  <= sq_neg_r[j-1];
      sq_zero_r[j] <= sq_zero_r[j-1];
    end
  end

  // three restoring dividers, one quotient bit a stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_st_r[0][i] <= div_step(LEN_W'(sq_mag_r[SQ_N-1][i][MAG_W-1:1]), '0,
                                sq_mag_r[SQ_N-1][i][0], sq_st_r[SQ_N-1].root);
    end
    dv_len_r[0]  <= sq_st_r[SQ_N-1].root;
    dv_neg_r[0]  <= sq_neg_r[SQ_N-1];
    dv_zero_r[0] <= sq_zero_r[SQ_N-1];
    for (int j = 1; j < DV_N; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_st_r[j][i] <= div_step(dv_st_r[j-1][i].rem, dv_st_r[j-1][i].q, 1'b0,
                                  dv_len_r[j-1]);
      end
      dv_len_r[j]  <= dv_len_r[j-1];
      dv_neg_r[j]  <= dv_neg_r[j-1];
      dv_zero_r[j] <= dv_zero_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      unit_r[i] <= dv_neg_r[DV_N-1][i] ? -$signed(U_W'(dv_st_r[DV_N-1][i].q))
                                       : $signed(U_W'(dv_st_r[DV_N-1][i].q));
    end
    zero_r <= dv_zero_r[DV_N-1];
  end

  assign unit_o = unit_r;
  assign zero_o = zero_r;

endmodule

FILE: src/bpsf_pow.sv
module bpsf_pow import bpsf_pkg::*; (
  input  logic              clk,
  input  logic [BASE_W-1:0] base_i,
  input  logic [SHINE_W-1:0] shine_i,
  output logic [BASE_W-1:0] res_o
);

  localparam int L_W  = K_W + LOG_FRAC;
  localparam int P_W  = L_W + SHINE_W;
  localparam int EI_W = P_W - 8 - LOG_FRAC;
  localparam coef_tab_t COEF = coef_tab();

  function automatic logic [BASE_W:0] sq_step(input logic [BASE_W-1:0] x);
    logic [2*BASE_W-1:0] p;
    logic [BASE_W:0]     s;
    p = x * x;
    s = p[2*BASE_W-1:Q_FRAC];
    return s[BASE_W] ? {1'b1, s[BASE_W:1]} : {1'b0, s[BASE_W-1:0]};
  endfunction

  logic [K_W-1:0]     msb_c, msb1_r, k2_r;
  logic [BASE_W-1:0]  base1_r, x2_r;
  logic [SHINE_W-1:0] sh1_r, sh2_r, shl_r;

  logic [BASE_W:0]     sq_c [LOG_FRAC];
  logic [BASE_W-1:0]   sqr_x_r [LOG_FRAC];
  logic [LOG_FRAC-1:0] sqr_f_r [LOG_FRAC];
  logic [K_W-1:0]      sqr_k_r [LOG_FRAC];
  logic [SHINE_W-1:0]  sqr_sh_r [LOG_FRAC];

  logic [L_W-1:0]      l_r;
  logic [P_W-1:0]      prod_c;
  logic [LOG_FRAC-1:0] f_r;
  logic [K_W-1:0]      ish_r;
  logic                huge_r;

  logic [BASE_W-1:0]   cm_c [LOG_FRAC];
  logic [BASE_W-1:0]   cf_r_r [LOG_FRAC];
  logic [LOG_FRAC-1:0] cf_f_r [LOG_FRAC];
  logic [K_W-1:0]      cf_ish_r [LOG_FRAC];
  logic                cf_huge_r [LOG_FRAC];
  logic [BASE_W-1:0]   res_r;

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < BASE_W; b++) begin
      if (base_i[b]) msb_c = K_W'(b);
    end
  end

  always_comb begin
    sq_c[0] = sq_step(x2_r);
    for (int j = 1; j < LOG_FRAC; j++) begin
      sq_c[j] = sq_step(sqr_x_r[j-1]);
    end
  end

  assign prod_c = l_r * shl_r;

  always_comb begin
    logic [BASE_W-1:0]   rin;
    logic [LOG_FRAC-1:0] fin;
    logic [BASE_W+COEF_W-1:0] p;
    for (int j = 0; j < LOG_FRAC; j++) begin
      rin = (j == 0) ? ONE_Q30 : cf_r_r[(j == 0) ? 0 : j-1];
      fin = (j == 0) ? f_r : cf_f_r[(j == 0) ? 0 : j-1];
      p = rin * COEF[j];
      cm_c[j] = fin[LOG_FRAC-1-j] ? p[BASE_W+COEF_W-1:Q_FRAC] : rin;
    end
  end

  always_ff @(posedge clk) begin
    base1_r <= base_i;
    msb1_r  <= msb_c;
    sh1_r   <= shine_i;
    k2_r    <= K_W'(Q_FRAC) - msb1_r;
    x2_r    <= base1_r << (K_W'(Q_FRAC) - msb1_r);
    sh2_r   <= sh1_r;

    sqr_x_r[0]  <= sq_c[0][BASE_W-1:0];
    sqr_f_r[0]  <= LOG_FRAC'(sq_c[0][BASE_W]);
    sqr_k_r[0]  <= k2_r;
    sqr_sh_r[0] <= sh2_r;
    for (int j = 1; j < LOG_FRAC; j++) begin
      sqr_x_r[j]  <= sq_c[j][BASE_W-1:0];
      sqr_f_r[j]  <= {sqr_f_r[j-1][LOG_FRAC-2:0], sq_c[j][BASE_W]};
      sqr_k_r[j]  <= sqr_k_r[j-1];
      sqr_sh_r[j] <= sqr_sh_r[j-1];
    end

    l_r   <= {sqr_k_r[LOG_FRAC-1], {LOG_FRAC{1'b0}}} - L_W'(sqr_f_r[LOG_FRAC-1]);
    shl_r <= sqr_sh_r[LOG_FRAC-1];

    f_r    <= prod_c[8+LOG_FRAC-1:8];
    ish_r  <= prod_c[8+LOG_FRAC+K_W-1:8+LOG_FRAC];
    huge_r <= (prod_c[P_W-1:8+LOG_FRAC] >= EI_W'(31));

    cf_r_r[0]    <= cm_c[0];
    cf_f_r[0]    <= f_r;
    cf_ish_r[0]  <= ish_r;
    cf_huge_r[0] <= huge_r;
    for (int j = 1; j < LOG_FRAC; j++) begin
      cf_r_r[j]    <= cm_c[j];
      cf_f_r[j]    <= cf_f_r[j-1];
      cf_ish_r[j]  <= cf_ish_r[j-1];
      cf_huge_r[j] <= cf_huge_r[j-1];
    end

    res_r <= cf_huge_r[LOG_FRAC-1] ? '0 : (cf_r_r[LOG_FRAC-1] >> cf_ish_r[LOG_FRAC-1]);
  end

  assign res_o = res_r;

endmodule

FILE: src/blinn_phong_specular_factor.sv
// Blinn-Phong specular factor. Start a word with start while busy is low; busy never rises,
// so one word can enter on every clock cycle. Each word gives one result on out_*, marked
// by a one-cycle out_valid that cannot be held off. The path runs through two vector
// normalisers in series (square root and divide, one bit per stage) and the power unit (24
// squaring and 24 multiply stages). Camera position registers sit at byte addresses 0, 4
// and 8 of the APB port; the user must write them only while no word is in flight, as the
// block itself does not enforce this.
module blinn_phong_specular_factor import bpsf_pkg::*; #(
  parameter int FACTOR_BITS = FACTOR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_point_z,
  input  logic signed [DATA_W-1:0] in_normal_x,
  input  logic signed [DATA_W-1:0] in_normal_y,
  input  logic signed [DATA_W-1:0] in_normal_z,
  input  logic signed [DATA_W-1:0] in_light_x,
  input  logic signed [DATA_W-1:0] in_light_y,
  input  logic signed [DATA_W-1:0] in_light_z,
  input  logic [SHINE_W-1:0]       in_shine_exponent,
  output logic                     out_valid,
  output logic [FACTOR_BITS:0]     out_specular_factor,
  output logic                     out_degenerate
);

  localparam logic [BASE_W:0]      HALF  = (BASE_W + 1)'(1) << (Q_FRAC - 1 - FACTOR_BITS);
  localparam logic [FACTOR_BITS:0] ONE_F = (FACTOR_BITS + 1)'(1) << FACTOR_BITS;

  typedef struct packed {
    logic degen;
    logic force_one;
    logic force_zero;
  } side_t;

  logic signed [DATA_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic wr;
  logic acc;

  vec_t dl_c [3], dc_c [3], nv_c [3];
  vec_t dl_r [3], dc_r [3], nv_r [3];
  logic [SHINE_W-1:0] shine_a_r;
  logic vld_a_r;

  unit_t ul_u [3], uc_u [3], un_u [3], uh_u [3];
  logic zl, zc, zn, zh;

  logic [NORM_LAT-1:0] vld_da_r;
  logic [SHINE_W-1:0]  shine_da_r [NORM_LAT];

  vec_t  h_r [3];
  unit_t un_b_r [3];
  logic  deg_b_r;
  logic [SHINE_W-1:0] shine_b_r;
  logic  vld_b_r;

  logic [NORM_LAT-1:0] vld_db_r;
  logic [NORM_LAT-1:0] deg_db_r;
  logic [SHINE_W-1:0]  shine_db_r [NORM_LAT];
  unit_t               un_db_r [NORM_LAT][3];

  logic signed [63:0] prod_r [3];
  logic signed [63:0] dot_r;
  logic               deg1_r, deg2_r;
  logic [SHINE_W-1:0] shine1_r, shine2_r, shine3_r;
  logic               vld1_r, vld2_r, vld3_r;
  logic [BASE_W-1:0]  base_c, base_r;
  logic [33:0]        bsh_c;
  side_t              side3_r;

  logic [BASE_W-1:0]  pow_res;
  logic [POW_LAT-1:0] vld_dp_r;
  side_t              side_dp_r [POW_LAT];

  side_t               side_p;
  logic [BASE_W-1:0]   rr_c;
  logic [BASE_W:0]     rnd_c;
  logic [FACTOR_BITS:0] fac_nxt;
  logic [FACTOR_BITS:0] fac_r;
  logic                 deg_r;
  logic                 out_valid_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr     = psel & penable & pwrite & pready;
  assign acc    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
    end else if (wr) begin
      case (paddr[CFG_AW-1:2])
        REG_CAMERA_X: cam_x_r <= pwdata;
        REG_CAMERA_Y: cam_y_r <= pwdata;
        REG_CAMERA_Z: cam_z_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_CAMERA_X: prdata = cam_x_r;
      REG_CAMERA_Y: prdata = cam_y_r;
      REG_CAMERA_Z: prdata = cam_z_r;
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    dl_c[0] = VEC_W'(in_light_x) - VEC_W'(in_point_x);
    dl_c[1] = VEC_W'(in_light_y) - VEC_W'(in_point_y);
    dl_c[2] = VEC_W'(in_light_z) - VEC_W'(in_point_z);
    dc_c[0] = VEC_W'(cam_x_r) - VEC_W'(in_point_x);
    dc_c[1] = VEC_W'(cam_y_r) - VEC_W'(in_point_y);
    dc_c[2] = VEC_W'(cam_z_r) - VEC_W'(in_point_z);
    nv_c[0] = VEC_W'(in_normal_x);
    nv_c[1] = VEC_W'(in_normal_y);
    nv_c[2] = VEC_W'(in_normal_z);
  end

  always_ff @(posedge clk) begin
    dl_r      <= dl_c;
    dc_r      <= dc_c;
    nv_r      <= nv_c;
    shine_a_r <= in_shine_exponent;
  end

  bpsf_norm3 u_norm_l (.clk(clk), .vec_i(dl_r), .unit_o(ul_u), .zero_o(zl));
  bpsf_norm3 u_norm_c (.clk(clk), .vec_i(dc_r), .unit_o(uc_u), .zero_o(zc));
  bpsf_norm3 u_norm_n (.clk(clk), .vec_i(nv_r), .unit_o(un_u), .zero_o(zn));

  // hold the shininess alongside the first normalisers
  always_ff @(posedge clk) begin
    shine_da_r[0] <= shine_a_r;
    for (int j = 1; j < NORM_LAT; j++) begin
      shine_da_r[j] <= shine_da_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      h_r[i] <= VEC_W'(ul_u[i]) + VEC_W'(uc_u[i]);
    end
    un_b_r    <= un_u;
    deg_b_r   <= zl | zc | zn;
    shine_b_r <= shine_da_r[NORM_LAT-1];
  end

  bpsf_norm3 u_norm_h (.clk(clk), .vec_i(h_r), .unit_o(uh_u), .zero_o(zh));

  always_ff @(posedge clk) begin
    shine_db_r[0] <= shine_b_r;
    un_db_r[0]    <= un_b_r;
    for (int j = 1; j < NORM_LAT; j++) begin
      shine_db_r[j] <= shine_db_r[j-1];
      un_db_r[j]    <= un_db_r[j-1];
    end
  end

  always_comb begin
    bsh_c = dot_r[63:Q_FRAC];
    if (dot_r <= 0) begin
      base_c = '0;
    end else if (bsh_c > 34'(ONE_Q30)) begin
      base_c = ONE_Q30;
    end else begin
      base_c = bsh_c[BASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= un_db_r[NORM_LAT-1][i] * uh_u[i];
    end
    deg1_r   <= deg_db_r[NORM_LAT-1] | zh;
    shine1_r <= shine_db_r[NORM_LAT-1];
    dot_r    <= prod_r[0] + prod_r[1] + prod_r[2];
    deg2_r   <= deg1_r;
    shine2_r <= shine1_r;
    base_r   <= base_c;
    shine3_r <= shine2_r;
    side3_r.degen      <= deg2_r;
    side3_r.force_one  <= (shine2_r == '0) || (base_c == ONE_Q30);
    side3_r.force_zero <= (base_c == '0);
  end

  bpsf_pow u_pow (.clk(clk), .base_i(base_r), .shine_i(shine3_r), .res_o(pow_res));

  always_ff @(posedge clk) begin
    side_dp_r[0] <= side3_r;
    for (int j = 1; j < POW_LAT; j++) begin
      side_dp_r[j] <= side_dp_r[j-1];
    end
  end

  assign side_p = side_dp_r[POW_LAT-1];

  always_comb begin
    if (side_p.force_one) begin
      rr_c = ONE_Q30;
    end else if (side_p.force_zero) begin
      rr_c = '0;
    end else begin
      rr_c = pow_res;
    end
    rnd_c   = (BASE_W + 1)'(rr_c) + HALF;
    fac_nxt = rnd_c[Q_FRAC -: FACTOR_BITS + 1];
    if (fac_nxt > ONE_F) fac_nxt = ONE_F;
    if (side_p.degen) fac_nxt = '0;
  end

  always_ff @(posedge clk) begin
    fac_r <= fac_nxt;
    deg_r <= side_p.degen;
  end

  // advance the word valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_da_r    <= '0;
      vld_b_r     <= 1'b0;
      vld_db_r    <= '0;
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld_dp_r    <= '0;
      out_valid_r <= 1'b0;
      deg_db_r    <= '0;
    end else begin
      vld_a_r     <= acc;
      vld_da_r    <= {vld_da_r[NORM_LAT-2:0], vld_a_r};
      vld_b_r     <= vld_da_r[NORM_LAT-1];
      vld_db_r    <= {vld_db_r[NORM_LAT-2:0], vld_b_r};
      deg_db_r    <= {deg_db_r[NORM_LAT-2:0], deg_b_r};
      vld1_r      <= vld_db_r[NORM_LAT-1];
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld_dp_r    <= {vld_dp_r[POW_LAT-2:0], vld3_r};
      out_valid_r <= vld_dp_r[POW_LAT-1];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_specular_factor = fac_r;
  assign out_degenerate      = deg_r;

endmodule

FILE: src/bpsf_chk.sv
module bpsf_chk import bpsf_pkg::*; #(
  parameter int FACTOR_BITS = FACTOR_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [CFG_AW-1:0]        paddr,
  input logic [DATA_W-1:0]        pwdata,
  input logic [DATA_W-1:0]        prdata,
  input logic                     pready,
  input logic                     start,
  input logic                     busy,
  input logic signed [DATA_W-1:0] in_point_x,
  input logic signed [DATA_W-1:0] in_point_y,
  input logic signed [DATA_W-1:0] in_point_z,
  input logic signed [DATA_W-1:0] in_normal_x,
  input logic signed [DATA_W-1:0] in_normal_y,
  input logic signed [DATA_W-1:0] in_normal_z,
  input logic signed [DATA_W-1:0] in_light_x,
  input logic signed [DATA_W-1:0] in_light_y,
  input logic signed [DATA_W-1:0] in_light_z,
  input logic [SHINE_W-1:0]       in_shine_exponent,
  input logic                     out_valid,
  input logic [FACTOR_BITS:0]     out_specular_factor,
  input logic                     out_degenerate
);

  localparam logic [FACTOR_BITS:0] ONE_F = (FACTOR_BITS + 1)'(1) << FACTOR_BITS;

  logic wr;
  assign wr = psel && penable && pwrite && pready &&
              (paddr[CFG_AW-1:2] == REG_CAMERA_X || paddr[CFG_AW-1:2] == REG_CAMERA_Y ||
               paddr[CFG_AW-1:2] == REG_CAMERA_Z);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without a word taken LAT cycles before");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_specular_factor == '0)
    else $error("degenerate word with nonzero factor");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_specular_factor <= ONE_F)
    else $error("factor above one");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    wr ##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
    else $error("camera register does not read back");

endmodule

bind blinn_phong_specular_factor bpsf_chk #(.FACTOR_BITS(FACTOR_BITS)) u_bpsf_chk (.*);
